### hw/rtl/dsa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the draw slot allocator.
package dsa_pkg;

    localparam int SLOT_DEPTH = 1024;
    localparam int ID_W       = $clog2(SLOT_DEPTH);
    localparam int CNT_W      = $clog2(SLOT_DEPTH + 1);
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 3;
    localparam int DATA_W     = 32;
    localparam int CFG_IDX_W  = 2;

    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd2;

    localparam logic [STATUS_W-1:0] STS_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] STS_NO_SLOT = 3'd1;
    localparam logic [STATUS_W-1:0] STS_VTX_OVF = 3'd2;
    localparam logic [STATUS_W-1:0] STS_IDX_OVF = 3'd3;
    localparam logic [STATUS_W-1:0] STS_INVALID = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DRAWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VTX_CAP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CAP    = 2'd2;

    localparam logic [CNT_W-1:0]  MAX_DRAWS_RST = CNT_W'(SLOT_DEPTH);
    localparam logic [DATA_W-1:0] CAP_RST       = '1;

    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic capture;
        logic execute;
    } t_dsa_cmd;

endpackage

### hw/rtl/draw_slot_allocator.sv
`timescale 1ns / 1ps
// Draw slot allocator: add, remove and update-check of draw slots.
//
// Input channel (i_in_valid / o_in_stall) carries one request item: mode,
// draw_id, vertex_count, index_count. Output channel (o_out_valid /
// i_out_stall) returns exactly one result item per request: status, slot_id,
// first_index, base_vertex, live_count.
// Each item has a capture step and an execute step: capture reads the free
// stack top and the active bit of draw_id; execute decides, writes both
// memories back and loads the result register. A new item is not accepted
// until the current one has executed; o_out_valid is registered and rises after execute.
// The result register lets a new item be accepted while the previous result
// waits; a second item then holds in its execute cycle until the output
// register is taken, and o_in_stall stays high meanwhile.
// Configuration writes (i_cfg_valid, always ready) select max_draws,
// vertex_capacity or index_capacity by index; issue them only while idle.
// Reset (synchronous, active low) empties the free stack, clears the fresh-ID
// counter, both bump pointers and the live count, and restores the config
// registers. Active bits need no clearing pass: an ID at or above the fresh
// counter reads as inactive.
module draw_slot_allocator
    import dsa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [MODE_W-1:0]    i_mode,
    input  logic [ID_W-1:0]      i_draw_id,
    input  logic [DATA_W-1:0]    i_vertex_count,
    input  logic [DATA_W-1:0]    i_index_count,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [STATUS_W-1:0]  o_status,
    output logic [ID_W-1:0]      o_slot_id,
    output logic [DATA_W-1:0]    o_first_index,
    output logic [DATA_W-1:0]    o_base_vertex,
    output logic [CNT_W-1:0]     o_live_count,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data
);

    t_dsa_cmd cmd;

    assign o_cfg_ready = 1'b1;

    dsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    dsa_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_mode         (i_mode),
        .i_draw_id      (i_draw_id),
        .i_vertex_count (i_vertex_count),
        .i_index_count  (i_index_count),
        .o_status       (o_status),
        .o_slot_id      (o_slot_id),
        .o_first_index  (o_first_index),
        .o_base_vertex  (o_base_vertex),
        .o_live_count   (o_live_count)
    );

endmodule

### hw/rtl/dsa_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences capture and execute of one item and owns the output valid.
module dsa_ctrl
    import dsa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_out_stall,
    output logic     o_in_stall,
    output logic     o_out_valid,
    output t_dsa_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid && i_out_stall;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        o_in_stall    = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.execute = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

### hw/rtl/dsa_dp.sv
`timescale 1ns / 1ps
// Datapath: config registers, free stack, active bits, bump pointers and result register.
module dsa_dp
    import dsa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dsa_cmd             i_cmd,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data,
    input  logic [MODE_W-1:0]    i_mode,
    input  logic [ID_W-1:0]      i_draw_id,
    input  logic [DATA_W-1:0]    i_vertex_count,
    input  logic [DATA_W-1:0]    i_index_count,
    output logic [STATUS_W-1:0]  o_status,
    output logic [ID_W-1:0]      o_slot_id,
    output logic [DATA_W-1:0]    o_first_index,
    output logic [DATA_W-1:0]    o_base_vertex,
    output logic [CNT_W-1:0]     o_live_count
);

    logic [CNT_W-1:0]  r_max_draws;
    logic [DATA_W-1:0] r_vtx_cap;
    logic [DATA_W-1:0] r_idx_cap;

    logic [CNT_W-1:0]  r_free_top,   n_free_top;
    logic [CNT_W-1:0]  r_next_fresh, n_next_fresh;
    logic [DATA_W-1:0] r_vtx_fill,   n_vtx_fill;
    logic [DATA_W-1:0] r_idx_fill,   n_idx_fill;
    logic [CNT_W-1:0]  r_total,      n_total;

    logic [ID_W-1:0] r_stack  [SLOT_DEPTH];
    logic            r_active [SLOT_DEPTH];
    logic [ID_W-1:0] r_stack_q;
    logic            r_active_q;

    logic [MODE_W-1:0] r_mode;
    logic [ID_W-1:0]   r_draw_id;
    logic [DATA_W-1:0] r_vcount;
    logic [DATA_W-1:0] r_icount;

    logic [STATUS_W-1:0] r_status,  n_status;
    logic [ID_W-1:0]     r_slot,    n_slot;
    logic [DATA_W-1:0]   r_first,   n_first;
    logic [DATA_W-1:0]   r_base,    n_base;

    logic [CNT_W-1:0]  limit;
    logic [CNT_W-1:0]  top_dec;
    logic              pop_ok;
    logic              fresh_ok;
    logic [ID_W-1:0]   take_id;
    logic              vtx_ovf;
    logic              idx_ovf;
    logic              slot_ok;
    logic              stack_we;
    logic [ID_W-1:0]   stack_waddr;
    logic [ID_W-1:0]   stack_wdata;
    logic              act_we;
    logic [ID_W-1:0]   act_waddr;
    logic              act_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_draws <= MAX_DRAWS_RST;
            r_vtx_cap   <= CAP_RST;
            r_idx_cap   <= CAP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_DRAWS: r_max_draws <= i_cfg_data[CNT_W-1:0];
                CFG_VTX_CAP:   r_vtx_cap   <= i_cfg_data;
                CFG_IDX_CAP:   r_idx_cap   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign top_dec = r_free_top - CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode     <= i_mode;
            r_draw_id  <= i_draw_id;
            r_vcount   <= i_vertex_count;
            r_icount   <= i_index_count;
            r_stack_q  <= r_stack[top_dec[ID_W-1:0]];
            r_active_q <= r_active[i_draw_id];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stack_we) begin
            r_stack[stack_waddr] <= stack_wdata;
        end
        if (act_we) begin
            r_active[act_waddr] <= act_wdata;
        end
    end

    assign limit    = (r_max_draws < CNT_W'(SLOT_DEPTH)) ? r_max_draws : CNT_W'(SLOT_DEPTH);
    assign pop_ok   = (r_free_top != '0);
    assign fresh_ok = (r_next_fresh < limit);
    assign take_id  = pop_ok ? r_stack_q : r_next_fresh[ID_W-1:0];
    assign vtx_ovf  = ({1'b0, r_vtx_fill} + {1'b0, r_vcount}) > {1'b0, r_vtx_cap};
    assign idx_ovf  = ({1'b0, r_idx_fill} + {1'b0, r_icount}) > {1'b0, r_idx_cap};
    assign slot_ok  = ({1'b0, r_draw_id} < limit)
                   && ({1'b0, r_draw_id} < r_next_fresh) && r_active_q;

    always_comb begin
        n_free_top   = r_free_top;
        n_next_fresh = r_next_fresh;
        n_vtx_fill   = r_vtx_fill;
        n_idx_fill   = r_idx_fill;
        n_total      = r_total;
        n_status     = STS_INVALID;
        n_slot       = '0;
        n_first      = '0;
        n_base       = '0;
        stack_we     = 1'b0;
        stack_waddr  = r_free_top[ID_W-1:0];
        stack_wdata  = take_id;
        act_we       = 1'b0;
        act_waddr    = take_id;
        act_wdata    = 1'b0;
        unique case (r_mode)
            MODE_ADD: begin
                if (!pop_ok && !fresh_ok) begin
                    n_status = STS_NO_SLOT;
                end else begin
                    if (!pop_ok) begin
                        n_next_fresh = r_next_fresh + CNT_W'(1);
                        act_we       = 1'b1;
                    end
                    if (vtx_ovf || idx_ovf) begin
                        n_status = vtx_ovf ? STS_VTX_OVF : STS_IDX_OVF;
                        if (!pop_ok) begin
                            stack_we   = 1'b1;
                            n_free_top = r_free_top + CNT_W'(1);
                        end
                    end else begin
                        n_status   = STS_OK;
                        n_slot     = take_id;
                        n_first    = r_idx_fill;
                        n_base     = r_vtx_fill;
                        act_we     = 1'b1;
                        act_wdata  = 1'b1;
                        n_vtx_fill = r_vtx_fill + r_vcount;
                        n_idx_fill = r_idx_fill + r_icount;
                        n_total    = r_total + CNT_W'(1);
                        if (pop_ok) begin
                            n_free_top = top_dec;
                        end
                    end
                end
            end
            MODE_REMOVE: begin
                if (slot_ok) begin
                    n_status  = STS_OK;
                    act_we    = 1'b1;
                    act_waddr = r_draw_id;
                    if (r_free_top < CNT_W'(SLOT_DEPTH)) begin
                        stack_we    = 1'b1;
                        stack_wdata = r_draw_id;
                        n_free_top  = r_free_top + CNT_W'(1);
                    end
                    if (r_total != '0) begin
                        n_total = r_total - CNT_W'(1);
                    end
                end
            end
            MODE_UPDATE: begin
                if (slot_ok) begin
                    n_status = STS_OK;
                end
            end
            default: begin
                n_status = STS_INVALID;
            end
        endcase
        if (!i_cmd.execute) begin
            stack_we = 1'b0;
            act_we   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_top   <= '0;
            r_next_fresh <= '0;
            r_vtx_fill   <= '0;
            r_idx_fill   <= '0;
            r_total      <= '0;
        end else if (i_cmd.execute) begin
            r_free_top   <= n_free_top;
            r_next_fresh <= n_next_fresh;
            r_vtx_fill   <= n_vtx_fill;
            r_idx_fill   <= n_idx_fill;
            r_total      <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_status <= n_status;
            r_slot   <= n_slot;
            r_first  <= n_first;
            r_base   <= n_base;
        end
    end

    assign o_status      = r_status;
    assign o_slot_id     = r_slot;
    assign o_first_index = r_first;
    assign o_base_vertex = r_base;
    assign o_live_count  = r_total;

endmodule
